FILE: hdl/fpr_pkg.sv
// fpr_pkg: shared types and constants of the fifo page replacement unit
// no dependencies; imported by the top level, the checker and the test bench

package fpr_pkg;

    // default sizes of the frame store and the page field
    localparam int MAX_FRAMES_DEF = 16;
    localparam int PAGE_BITS_DEF  = 16;

    // at most this many frames are ever in use, whatever the store depth
    localparam int RESULT_LIMIT   = 16;

    // fixed field widths
    localparam int CFG_W   = 5;
    localparam int SLOT_W  = 4;
    localparam int TOTAL_W = 32;

    // frame count after reset
    localparam logic [CFG_W-1:0] FRAME_COUNT_RST = 5'd4;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_HIT,
        S_WRITE,
        S_LREAD,
        S_LEMIT
    } t_state;

endpackage

FILE: hdl/fpr_frame_ram.sv
// fpr_frame_ram: frame store, one write port and one registered read port
// no dependencies; instantiated by fifo_page_replacement_unit

module fpr_frame_ram #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/fifo_page_replacement_unit.sv
// fifo_page_replacement_unit: top level of the fifo page replacement unit
// depends on fpr_pkg and fpr_frame_ram

// One page reference is taken per request (start high while busy is low).
// The unit scans the filled frames one at a time through a single compare
// unit fed by the frame store's registered read port, which reads each frame
// in S_READ and compares it in S_CMP. A hit at frame k gives one result.
// A miss after scanning u frames writes the page at the round-robin pointer
// and lists all f filled frames, each in S_LREAD and then S_LEMIT, while
// busy stays high. Each result shows on the o_ result ports for one cycle
// with o_strobe high, in the cycle after it is formed; the receiver cannot
// stall it. The fault counter saturates. After a request with
// i_final_reference set, the frames, the pointer and the counter clear
// once its results are out. The frame count is written through the cfg
// channel, which is ready whenever the unit is idle.

module fifo_page_replacement_unit #(
    parameter int MAX_FRAMES = fpr_pkg::MAX_FRAMES_DEF,
    parameter int PAGE_BITS  = fpr_pkg::PAGE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // request channel
    input  logic                       start,
    output logic                       busy,
    input  logic [PAGE_BITS-1:0]       i_page_number,
    input  logic                       i_final_reference,
    // result channel
    output logic                       o_strobe,
    output logic                       o_page_fault,
    output logic [fpr_pkg::SLOT_W-1:0] o_frame_slot,
    output logic [PAGE_BITS-1:0]       o_frame_page,
    output logic                       o_last_of_run,
    output logic [fpr_pkg::TOTAL_W-1:0] o_fault_total,
    // configuration channel
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [fpr_pkg::CFG_W-1:0]  i_cfg_data
);

    import fpr_pkg::*;

    localparam int EFF_MAX = (MAX_FRAMES < RESULT_LIMIT) ? MAX_FRAMES : RESULT_LIMIT;
    localparam int IDX_W   = (EFF_MAX > 1) ? $clog2(EFF_MAX) : 1;
    localparam int CNT_W   = $clog2(EFF_MAX + 1);
    localparam logic [CFG_W-1:0] EFF_MAX_CFG = CFG_W'(EFF_MAX);

    // sequencer and datapath registers
    t_state               r_state, n_state;
    logic [CFG_W-1:0]     r_cfg;
    logic [PAGE_BITS-1:0] r_page, n_page;
    logic                 r_final, n_final;
    logic [CNT_W-1:0]     r_fc, n_fc;
    logic [CNT_W-1:0]     r_used, n_used;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [CNT_W-1:0]     r_filled, n_filled;
    logic [IDX_W-1:0]     r_ptr, n_ptr;
    logic [TOTAL_W-1:0]   r_count, n_count;

    // result registers
    logic                 r_strobe, n_strobe;
    logic                 r_fault, n_fault;
    logic [SLOT_W-1:0]    r_slot, n_slot;
    logic [PAGE_BITS-1:0] r_fpage, n_fpage;
    logic                 r_last, n_last;
    logic [TOTAL_W-1:0]   r_total, n_total;

    // helpers
    logic                 accept;
    logic [CNT_W-1:0]     cfg_eff;
    logic [CNT_W-1:0]     used_now;
    logic [IDX_W-1:0]     wr_ptr;
    logic [CNT_W-1:0]     idx_next;
    logic                 match;
    logic                 ram_we;
    logic [PAGE_BITS-1:0] ram_rdata;

    assign accept = start && (r_state == S_IDLE);

    // frame count clipped to the usable range
    always_comb begin
        if (r_cfg == '0) begin
            cfg_eff = CNT_W'(1);
        end else if (r_cfg > EFF_MAX_CFG) begin
            cfg_eff = CNT_W'(EFF_MAX);
        end else begin
            cfg_eff = CNT_W'(r_cfg);
        end
    end

    assign used_now = (r_filled < cfg_eff) ? r_filled : cfg_eff;

    // pointer wraps before use when the frame count was lowered
    assign wr_ptr   = (CNT_W'(r_ptr) >= r_fc) ? '0 : r_ptr;
    assign idx_next = CNT_W'(r_idx) + CNT_W'(1);

    // shared compare unit
    assign match  = (ram_rdata == r_page);
    assign ram_we = (r_state == S_WRITE);

    fpr_frame_ram #(
        .DEPTH  (EFF_MAX),
        .WIDTH  (PAGE_BITS),
        .ADDR_W (IDX_W)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (wr_ptr),
        .i_wdata (r_page),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (used_now == '0) ? S_WRITE : S_READ;
                end
            end
            S_READ: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (match) begin
                    n_state = S_HIT;
                end else if (idx_next == r_used) begin
                    n_state = S_WRITE;
                end else begin
                    n_state = S_READ;
                end
            end
            S_HIT: begin
                n_state = S_IDLE;
            end
            S_WRITE: begin
                n_state = S_LREAD;
            end
            S_LREAD: begin
                n_state = S_LEMIT;
            end
            S_LEMIT: begin
                n_state = (idx_next == r_filled) ? S_IDLE : S_LREAD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath and result values
    always_comb begin
        n_page   = r_page;
        n_final  = r_final;
        n_fc     = r_fc;
        n_used   = r_used;
        n_idx    = r_idx;
        n_filled = r_filled;
        n_ptr    = r_ptr;
        n_count  = r_count;
        n_strobe = 1'b0;
        n_fault  = r_fault;
        n_slot   = r_slot;
        n_fpage  = r_fpage;
        n_last   = r_last;
        n_total  = r_total;
        case (r_state)
            S_IDLE: begin
                // latch the request
                if (accept) begin
                    n_page  = i_page_number;
                    n_final = i_final_reference;
                    n_fc    = cfg_eff;
                    n_used  = used_now;
                    n_idx   = '0;
                end
            end
            S_CMP: begin
                if (!match && (idx_next != r_used)) begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_HIT: begin
                n_strobe = 1'b1;
                n_fault  = 1'b0;
                n_slot   = '0;
                n_fpage  = '0;
                n_last   = 1'b1;
                n_total  = r_count;
                if (r_final) begin
                    n_filled = '0;
                    n_ptr    = '0;
                    n_count  = '0;
                end
            end
            S_WRITE: begin
                // replace at the pointer, bump pointer and fault count
                n_ptr    = (CNT_W'(wr_ptr) + CNT_W'(1) >= r_fc) ? '0 : wr_ptr + IDX_W'(1);
                n_count  = (r_count != '1) ? r_count + TOTAL_W'(1) : r_count;
                n_filled = (r_used + CNT_W'(1) > r_fc) ? r_fc : r_used + CNT_W'(1);
                n_idx    = '0;
            end
            S_LEMIT: begin
                n_strobe = 1'b1;
                n_fault  = 1'b1;
                n_slot   = SLOT_W'(r_idx);
                n_fpage  = ram_rdata;
                n_last   = (idx_next == r_filled);
                n_total  = r_count;
                if (idx_next == r_filled) begin
                    if (r_final) begin
                        n_filled = '0;
                        n_ptr    = '0;
                        n_count  = '0;
                    end
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cfg    <= FRAME_COUNT_RST;
            r_filled <= '0;
            r_ptr    <= '0;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_filled <= n_filled;
            r_ptr    <= n_ptr;
            r_count  <= n_count;
            r_strobe <= n_strobe;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_page  <= n_page;
        r_final <= n_final;
        r_fc    <= n_fc;
        r_used  <= n_used;
        r_idx   <= n_idx;
        r_fault <= n_fault;
        r_slot  <= n_slot;
        r_fpage <= n_fpage;
        r_last  <= n_last;
        r_total <= n_total;
    end

    // ports
    assign busy          = (r_state != S_IDLE);
    assign o_cfg_ready   = (r_state == S_IDLE);
    assign o_strobe      = r_strobe;
    assign o_page_fault  = r_fault;
    assign o_frame_slot  = r_slot;
    assign o_frame_page  = r_fpage;
    assign o_last_of_run = r_last;
    assign o_fault_total = r_total;

    // a result only follows a hit or a listing step
    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(r_state) == S_HIT || $past(r_state) == S_LEMIT))
        else $error("result strobe without a hit or listing step");

    // a hit result is always the only and last one
    a_hit_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_page_fault) |-> o_last_of_run)
        else $error("hit result not marked last");

    // an accepted request makes the unit busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but unit not busy");

    // filled frames never exceed the usable frame count
    a_filled_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filled <= CNT_W'(EFF_MAX))
        else $error("filled frame count out of range");

endmodule

FILE: bench/fpr_checker.sv
`timescale 1ns / 100ps
// fpr_checker: watches the request, result and cfg channels of the page replacement unit
// predicts the frame listing of every request and compares; depends on fpr_pkg

module fpr_checker #(
    parameter int MAX_FRAMES = fpr_pkg::MAX_FRAMES_DEF,
    parameter int PAGE_BITS  = fpr_pkg::PAGE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_busy,
    input  logic [PAGE_BITS-1:0]        i_page_number,
    input  logic                        i_final_reference,
    input  logic                        i_strobe,
    input  logic                        i_page_fault,
    input  logic [fpr_pkg::SLOT_W-1:0]  i_frame_slot,
    input  logic [PAGE_BITS-1:0]        i_frame_page,
    input  logic                        i_last_of_run,
    input  logic [fpr_pkg::TOTAL_W-1:0] i_fault_total,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  logic [fpr_pkg::CFG_W-1:0]   i_cfg_data,
    output int                          o_mismatches,
    output int                          o_pending
);

    import fpr_pkg::*;

    // one entry of the frame listing
    typedef struct packed {
        logic                 page_fault;
        logic [SLOT_W-1:0]    frame_slot;
        logic [PAGE_BITS-1:0] frame_page;
        logic                 last_of_run;
        logic [TOTAL_W-1:0]   fault_total;
    } t_frame_report;

    t_frame_report        reports_due[$];
    logic [PAGE_BITS-1:0] resident[MAX_FRAMES];
    int unsigned          filled_cnt;
    int unsigned          replace_ptr;
    logic [TOTAL_W-1:0]   fault_cnt;
    logic [CFG_W-1:0]     frame_cnt;
    int                   mismatch_cnt;

    // frame count as the unit uses it: zero acts as one, clamped to the store depth
    function automatic int unsigned frames_in_use();
        int unsigned f;
        f = 32'(frame_cnt);
        if (f == 0) f = 1;
        if (f > MAX_FRAMES) f = MAX_FRAMES;
        if (f > RESULT_LIMIT) f = RESULT_LIMIT;
        return f;
    endfunction

    task automatic note_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatch_cnt++;
    endtask

    // look up one page, replace on a miss and queue the listing it causes
    task automatic replace_page(input logic [PAGE_BITS-1:0] pg, input logic last_ref);
        int unsigned   fc;
        int unsigned   used;
        int unsigned   slot;
        bit            hit;
        t_frame_report rep;
        fc   = frames_in_use();
        used = (filled_cnt < fc) ? filled_cnt : fc;
        hit  = 0;
        for (int unsigned i = 0; i < used; i++) begin
            if (resident[i] == pg) hit = 1;
        end
        if (hit) begin
            rep.page_fault  = 1'b0;
            rep.frame_slot  = '0;
            rep.frame_page  = '0;
            rep.last_of_run = 1'b1;
            rep.fault_total = fault_cnt;
            reports_due.push_back(rep);
        end else begin
            // pointer left beyond a lowered frame count wraps before use
            slot = (replace_ptr >= fc) ? 0 : replace_ptr;
            resident[slot] = pg;
            replace_ptr = (slot + 1 >= fc) ? 0 : slot + 1;
            if (fault_cnt != '1) fault_cnt++;
            used = (used + 1 > fc) ? fc : used + 1;
            filled_cnt = used;
            for (int unsigned i = 0; i < used; i++) begin
                rep.page_fault  = 1'b1;
                rep.frame_slot  = SLOT_W'(i);
                rep.frame_page  = resident[i];
                rep.last_of_run = (i + 1 == used);
                rep.fault_total = fault_cnt;
                reports_due.push_back(rep);
            end
        end
        // end of string: results above already show the state before clearing
        if (last_ref) begin
            filled_cnt  = 0;
            replace_ptr = 0;
            fault_cnt   = '0;
        end
    endtask

    // compare one result with the oldest queued entry, field by field
    task automatic check_report();
        t_frame_report want;
        if (reports_due.size() == 0) begin
            note_mismatch($sformatf("result with nothing pending: slot %0d page %0h",
                                    i_frame_slot, i_frame_page));
        end else begin
            want = reports_due.pop_front();
            if (i_page_fault !== want.page_fault)
                note_mismatch($sformatf("page_fault got %0b, wanted %0b",
                                        i_page_fault, want.page_fault));
            if (i_frame_slot !== want.frame_slot)
                note_mismatch($sformatf("frame_slot got %0d, wanted %0d",
                                        i_frame_slot, want.frame_slot));
            if (i_frame_page !== want.frame_page)
                note_mismatch($sformatf("frame_page got %0h, wanted %0h",
                                        i_frame_page, want.frame_page));
            if (i_last_of_run !== want.last_of_run)
                note_mismatch($sformatf("last_of_run got %0b, wanted %0b",
                                        i_last_of_run, want.last_of_run));
            if (i_fault_total !== want.fault_total)
                note_mismatch($sformatf("fault_total got %0d, wanted %0d",
                                        i_fault_total, want.fault_total));
        end
    endtask

    // results first: a trailing result belongs to the request before this edge
    // a request taken at the same edge as a cfg write still sees the old frame count
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reports_due.delete();
            filled_cnt   = 0;
            replace_ptr  = 0;
            fault_cnt    = '0;
            frame_cnt    = FRAME_COUNT_RST;
            mismatch_cnt = 0;
        end else begin
            if (i_strobe) check_report();
            if (i_start && !i_busy) replace_page(i_page_number, i_final_reference);
            if (i_cfg_valid && i_cfg_ready) frame_cnt = i_cfg_data;
        end
        o_pending    = reports_due.size();
        o_mismatches = mismatch_cnt;
    end

endmodule

FILE: bench/fifo_page_replacement_unit_test.sv
`timescale 1ns / 100ps
// fifo_page_replacement_unit_test: stimulus and verdict for the page replacement unit
// depends on fpr_pkg, fifo_page_replacement_unit and fpr_checker

module fifo_page_replacement_unit_test;

    import fpr_pkg::*;

    localparam int QUIET_LIMIT  = 4000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 30;
    localparam int SETTLE_TICKS = 6;

    logic                 i_clk             = 1'b0;
    logic                 i_rst_n           = 1'b0;
    logic                 start             = 1'b0;
    logic [15:0]          i_page_number     = '0;
    logic                 i_final_reference = 1'b0;
    logic                 i_cfg_valid       = 1'b0;
    logic [CFG_W-1:0]     i_cfg_data        = '0;
    logic                 busy;
    logic                 o_strobe;
    logic                 o_page_fault;
    logic [SLOT_W-1:0]    o_frame_slot;
    logic [15:0]          o_frame_page;
    logic                 o_last_of_run;
    logic [TOTAL_W-1:0]   o_fault_total;
    logic                 o_cfg_ready;
    int                   mismatches;
    int                   pending;
    int                   send_idle_pct = 30;
    int                   quiet_cycles  = 0;

    // frame count per phase and how often the sender idles in it
    logic [CFG_W-1:0] phase_frames[PHASES] = '{5'd2, 5'd0, 5'd31, 5'd1,
                                               5'd16, 5'd17, 5'd9, 5'd3};
    int               phase_idle[PHASES]   = '{30, 30, 30, 67, 67, 67, 0, 0};

    always #5 i_clk = ~i_clk;

    fifo_page_replacement_unit u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_page_number     (i_page_number),
        .i_final_reference (i_final_reference),
        .o_strobe          (o_strobe),
        .o_page_fault      (o_page_fault),
        .o_frame_slot      (o_frame_slot),
        .o_frame_page      (o_frame_page),
        .o_last_of_run     (o_last_of_run),
        .o_fault_total     (o_fault_total),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data)
    );

    fpr_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (start),
        .i_busy            (busy),
        .i_page_number     (i_page_number),
        .i_final_reference (i_final_reference),
        .i_strobe          (o_strobe),
        .i_page_fault      (o_page_fault),
        .i_frame_slot      (o_frame_slot),
        .i_frame_page      (o_frame_page),
        .i_last_of_run     (o_last_of_run),
        .i_fault_total     (o_fault_total),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .o_mismatches      (mismatches),
        .o_pending         (pending)
    );

    // watchdog: too long without any handshake or result ends the run
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic int usable_frames(input logic [CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > RESULT_LIMIT) return RESULT_LIMIT;
        return int'(v);
    endfunction

    // one request; start stays high across back-to-back requests
    task automatic send_reference(input logic [15:0] pg, input logic last_ref);
        while ($urandom_range(99) < send_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start             <= 1'b1;
        i_page_number     <= pg;
        i_final_reference <= last_ref;
        do @(posedge i_clk); while (busy);
    endtask

    // wait for every queued result, then let the end-of-string clear settle
    task automatic wait_drained();
        do @(negedge i_clk); while (pending != 0);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic write_frame_count(input logic [CFG_W-1:0] v);
        start <= 1'b0;
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [15:0]      page_pool[RESULT_LIMIT + 3];
        logic [15:0]      pg;
        logic             last_ref;
        logic [CFG_W-1:0] active_cfg;
        int               fc;
        int               pool_size;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at the reset frame count of four
        send_reference(16'h0000, 1'b0);   // lowest page, first fault
        send_reference(16'hFFFF, 1'b0);   // highest page
        send_reference(16'h0000, 1'b0);   // hit in the first frame
        send_reference(16'hFFFF, 1'b0);
        send_reference(16'h1234, 1'b0);
        send_reference(16'h8000, 1'b0);   // all four frames filled
        send_reference(16'h8000, 1'b0);   // hit in the last frame
        send_reference(16'h0001, 1'b0);   // pointer wrapped, evicts page 0
        send_reference(16'h0000, 1'b0);   // evicted page faults again
        send_reference(16'h0001, 1'b0);
        send_reference(16'hAAAA, 1'b1);   // end of string on a fault
        send_reference(16'h0001, 1'b0);   // cleared frames: faults again
        send_reference(16'h0001, 1'b1);   // end of string on a hit
        send_reference(16'h5555, 1'b0);
        send_reference(16'h0010, 1'b0);
        send_reference(16'h0020, 1'b0);   // three filled, pointer at three

        // random phases; lowered counts land mid-string, raised ones on a clean string
        active_cfg = FRAME_COUNT_RST;
        for (int ph = 0; ph < PHASES; ph++) begin
            write_frame_count(phase_frames[ph]);
            send_idle_pct = phase_idle[ph];
            active_cfg    = phase_frames[ph];
            fc            = usable_frames(active_cfg);
            pool_size     = fc + 3;
            for (int k = 0; k < pool_size; k++) page_pool[k] = 16'($urandom_range(16'hFFFF));
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(99) < 85)
                    pg = page_pool[$urandom_range(pool_size - 1)];
                else
                    pg = 16'($urandom_range(16'hFFFF));
                last_ref = ($urandom_range(99) < 6);
                if (k == PHASE_ITEMS - 1 && ph < PHASES - 1 &&
                    usable_frames(phase_frames[ph + 1]) > fc)
                    last_ref = 1'b1;
                send_reference(pg, last_ref);
            end
        end

        // drain and give the verdict
        start <= 1'b0;
        wait_drained();
        @(negedge i_clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
